// ===== hdl/matrix_inverse_3x3_unit_defines.svh =====
// assertion macros shared by the rtl
`ifndef MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH
`define MATRIX_INVERSE_3X3_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define MI3_ASSERT_IMPL(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// condition implies consequence in the next cycle
`define MI3_ASSERT_NEXT(label, clk, rstn, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/mi3_pkg.sv =====
package mi3_pkg;

    localparam int N_ELEM = 9;

    // element indices of the two products of each cofactor: a*b - c*d
    localparam int unsigned COF_IDX [9][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef struct packed {
        logic sing;
        logic clip;
    } lane_flags_t;

endpackage

// ===== hdl/mi3_front.sv =====
module mi3_front #(
    parameter int W = 32
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic signed [W-1:0]   elem [9],
    output logic signed [2*W:0]   cof [9],
    output logic [3*W+1:0]        dmag,
    output logic                  dneg,
    output logic                  dzero
);
    import mi3_pkg::*;

    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 2;
    localparam int PW = 2 * W;
    localparam int LW = 2 * W + 2;

    logic signed [W-1:0]  e_p0_reg [9];
    logic signed [PW-1:0] pa_p1_reg [9];
    logic signed [PW-1:0] pb_p1_reg [9];
    logic signed [W-1:0]  e_p1_reg [3];
    logic signed [CW-1:0] cof_p2_reg [9];
    logic signed [W-1:0]  e_p2_reg [3];
    logic signed [LW-1:0] lo_p3_reg [3];
    logic signed [PW-1:0] hi_p3_reg [3];
    logic signed [CW-1:0] cof_p3_reg [9];
    logic signed [DW-1:0] det_p4_reg;
    logic signed [CW-1:0] cof_p4_reg [9];
    logic [DW-1:0]        dmag_p5_reg;
    logic                 dneg_p5_reg;
    logic                 dzero_p5_reg;
    logic signed [CW-1:0] cof_p5_reg [9];
    logic signed [DW-1:0] det_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                e_p0_reg[k]   <= elem[k];
                pa_p1_reg[k]  <= e_p0_reg[COF_IDX[k][0]] * e_p0_reg[COF_IDX[k][1]];
                pb_p1_reg[k]  <= e_p0_reg[COF_IDX[k][2]] * e_p0_reg[COF_IDX[k][3]];
                cof_p2_reg[k] <= CW'(pa_p1_reg[k]) - CW'(pb_p1_reg[k]);
                cof_p3_reg[k] <= cof_p2_reg[k];
                cof_p4_reg[k] <= cof_p3_reg[k];
                cof_p5_reg[k] <= cof_p4_reg[k];
            end
            for (int j = 0; j < 3; j++) begin
                e_p1_reg[j]  <= e_p0_reg[3*j];
                e_p2_reg[j]  <= e_p1_reg[j];
                // split the cofactor into an unsigned low part and a signed high part
                lo_p3_reg[j] <= e_p2_reg[j] * $signed({1'b0, cof_p2_reg[j][W:0]});
                hi_p3_reg[j] <= e_p2_reg[j] * $signed(cof_p2_reg[j][CW-1:W+1]);
            end
            det_p4_reg   <= det_next;
            dmag_p5_reg  <= det_p4_reg[DW-1] ? DW'(-det_p4_reg) : DW'(det_p4_reg);
            dneg_p5_reg  <= det_p4_reg[DW-1];
            dzero_p5_reg <= (det_p4_reg == '0);
        end
    end

    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + (DW'(hi_p3_reg[j]) <<< (W + 1)) + DW'(lo_p3_reg[j]);
        end
    end

    assign cof   = cof_p5_reg;
    assign dmag  = dmag_p5_reg;
    assign dneg  = dneg_p5_reg;
    assign dzero = dzero_p5_reg;

endmodule

// ===== hdl/mi3_div_lane.sv =====
module mi3_div_lane #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [2*W:0]     cof,
    input  logic [3*W+1:0]          dmag,
    input  logic                    dneg,
    input  logic                    dzero,
    output logic signed [W-1:0]     quot,
    output mi3_pkg::lane_flags_t    flags
);
    import mi3_pkg::*;

    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 2;
    localparam int NMW = CW + 2 * F;
    localparam int RW  = ((NMW > DW + W) ? NMW : DW + W) + 1;

    logic [RW-1:0] r_reg   [W+1];
    logic [W-1:0]  q_reg   [W+1];
    logic [DW-1:0] d_reg   [W+1];
    logic          neg_reg [W+1];
    logic          ovf_reg [W+1];
    logic          dz_reg  [W+1];
    logic signed [W-1:0] quot_reg;
    lane_flags_t         flags_reg;

    logic [CW-1:0] cmag;
    logic [RW-1:0] num;
    logic [W-1:0]  lim;
    logic [W-1:0]  mag;
    logic          clip_now;

    assign cmag = cof[CW-1] ? CW'(-cof) : CW'(cof);
    assign num  = RW'(cmag) << (2 * F);

    // quotient beyond W bits is caught up front, so W restoring steps suffice
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0]   <= num;
            q_reg[0]   <= '0;
            d_reg[0]   <= dmag;
            neg_reg[0] <= cof[CW-1] ^ dneg;
            ovf_reg[0] <= (num >= (RW'(dmag) << W));
            dz_reg[0]  <= dzero;
        end
    end

    for (genvar k = 1; k <= W; k++) begin : g_step
        localparam int B = W - k;
        logic [RW:0] trial;
        assign trial = {1'b0, r_reg[k-1]} - ({1'b0, RW'(d_reg[k-1])} << B);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!trial[RW]) begin
                    r_reg[k] <= trial[RW-1:0];
                    q_reg[k] <= q_reg[k-1] | (W'(1) << B);
                end else begin
                    r_reg[k] <= r_reg[k-1];
                    q_reg[k] <= q_reg[k-1];
                end
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
                dz_reg[k]  <= dz_reg[k-1];
            end
        end
    end

    assign lim      = neg_reg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign clip_now = ovf_reg[W] || (q_reg[W] > lim);
    assign mag      = clip_now ? lim : q_reg[W];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (dz_reg[W]) begin
                quot_reg  <= '0;
                flags_reg <= '{sing: 1'b1, clip: 1'b0};
            end else begin
                quot_reg  <= neg_reg[W] ? $signed(-mag) : $signed(mag);
                flags_reg <= '{sing: 1'b0, clip: clip_now};
            end
        end
    end

    assign quot  = quot_reg;
    assign flags = flags_reg;

endmodule

// ===== hdl/matrix_inverse_3x3_unit.sv =====
// 3x3 matrix inverse by the adjugate, signed fixed point.
// s_ channel: one item is a matrix, nine elements packed in s_tdata, element 0
// in the lowest bits. m_ channel: one item is the inverse, packed the same way,
// with m_tuser[0] = singular (elements then zero) and m_tuser[1] = clipped.
// Quotients are truncated toward zero and saturated to the word range.
// Throughput: one item per clock while s_tready is high. The pipeline runs through six
// stages of products, cofactors and determinant, then one prepare stage, WORD_BITS
// restoring divide steps and one saturate stage in each of nine lanes, then the merge.
// Reset (aresetn low, synchronous) empties the pipeline by clearing its valid bits; data registers are not reset.
// A stalled receiver holds the result in the output register while one more
// item lands in a skid register; only then does s_tready fall and the whole
// pipeline freeze, resuming without loss once m_tready returns.
module matrix_inverse_3x3_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((9*WORD_BITS+7)/8)*8-1:0]      s_tdata,  // in_e0 .. in_e8
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((9*WORD_BITS+7)/8)*8-1:0]      m_tdata,  // out_e0 .. out_e8
    output logic [1:0]                            m_tuser   // singular, clipped
);
    import mi3_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int CW  = 2 * W + 1;
    localparam int DW  = 3 * W + 2;
    localparam int TDW = ((9 * W + 7) / 8) * 8;
    localparam int NS  = 6 + W + 2;

    logic                 en;
    logic [NS-1:0]        v_reg;
    logic signed [W-1:0]  elem [9];
    logic signed [CW-1:0] cof [9];
    logic [DW-1:0]        dmag;
    logic                 dneg;
    logic                 dzero;
    logic signed [W-1:0]  quot [9];
    lane_flags_t          lflags [9];
    logic [TDW-1:0]       mdata;
    logic [1:0]           muser;
    logic [TDW-1:0]       out_data_reg, skid_data_reg;
    logic [1:0]           out_user_reg, skid_user_reg;
    logic                 out_v_reg, skid_v_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    for (genvar k = 0; k < 9; k++) begin : g_elem
        assign elem[k] = $signed(s_tdata[k*W +: W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NS-2:0], s_tvalid};
        end
    end

    mi3_front #(.W(W)) u_front (
        .aclk  (aclk),
        .en    (en),
        .elem  (elem),
        .cof   (cof),
        .dmag  (dmag),
        .dneg  (dneg),
        .dzero (dzero)
    );

    for (genvar k = 0; k < 9; k++) begin : g_lane
        mi3_div_lane #(.W(W), .F(FRAC_BITS)) u_lane (
            .aclk  (aclk),
            .en    (en),
            .cof   (cof[k]),
            .dmag  (dmag),
            .dneg  (dneg),
            .dzero (dzero),
            .quot  (quot[k]),
            .flags (lflags[k])
        );
    end

    // merge the lanes into one item
    always_comb begin
        mdata    = '0;
        muser    = '0;
        muser[0] = lflags[0].sing;
        for (int k = 0; k < 9; k++) begin
            mdata[k*W +: W] = quot[k];
            muser[1]        = muser[1] | lflags[k].clip;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (skid_v_reg) begin
                if (m_tready) begin
                    skid_v_reg <= 1'b0;
                end
            end else if (v_reg[NS-1]) begin
                if (!out_v_reg || m_tready) begin
                    out_v_reg <= 1'b1;
                end else begin
                    skid_v_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_tready) begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
        end else if (v_reg[NS-1]) begin
            if (!out_v_reg || m_tready) begin
                out_data_reg <= mdata;
                out_user_reg <= muser;
            end else begin
                skid_data_reg <= mdata;
                skid_user_reg <= muser;
            end
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

`include "matrix_inverse_3x3_unit_defines.svh"

    `MI3_ASSERT_IMPL(a_sing_zero, aclk, aresetn, m_tvalid && m_tuser[0], !m_tuser[1] && m_tdata == '0)
    `MI3_ASSERT_IMPL(a_ready_drained, aclk, aresetn, !m_tvalid, s_tready)
    `MI3_ASSERT_NEXT(a_skid_drains, aclk, aresetn, !s_tready && m_tready, s_tready)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int W = 32;
    localparam int F = 16;
    localparam int DW = ((9*W+7)/8)*8;
    localparam int LATENCY = W + 8;
    localparam int N_RANDOM = 830;
    localparam longint CYCLE_LIMIT = 400000;

    typedef logic signed [W-1:0] elem_t;
    typedef struct {
        elem_t e[9];
    } matrix_t;
    typedef struct {
        elem_t e[9];
        logic sing;
        logic clip;
    } inverse_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [DW-1:0] m_tdata;
    logic [1:0] m_tuser;

    matrix_inverse_3x3_unit #(.WORD_BITS(W), .FRAC_BITS(F)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    matrix_t pending_mats[$];
    inverse_t expected_inv[$];
    int errors = 0;
    int accepted = 0;
    int total_items = 0;
    bit quiet_tail = 0;
    bit hold_sender = 0;
    int send_gap = 0;
    int recv_gap = 0;

    // handshake at the last rising edge, for the driver at the falling edge
    logic s_tready_q = 1'b0;

    // exact adjugate inverse, truncated toward zero and saturated
    function automatic inverse_t invert(matrix_t m);
        inverse_t r;
        logic signed [191:0] x[9];
        logic signed [191:0] cof[9];
        logic signed [191:0] det;
        logic signed [191:0] num;
        logic signed [191:0] q;
        logic signed [191:0] pmax;
        logic signed [191:0] nmin;
        int pick[9][4];
        pick = '{'{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
                 '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
                 '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}};
        pmax = (192'sd1 <<< (W-1)) - 1;
        nmin = -(192'sd1 <<< (W-1));
        for (int k = 0; k < 9; k++) x[k] = m.e[k];
        for (int k = 0; k < 9; k++)
            cof[k] = x[pick[k][0]]*x[pick[k][1]] - x[pick[k][2]]*x[pick[k][3]];
        det = x[0]*cof[0] + x[3]*cof[1] + x[6]*cof[2];
        r.sing = (det == 0);
        r.clip = 1'b0;
        for (int k = 0; k < 9; k++) begin
            if (r.sing) begin
                r.e[k] = '0;
            end else begin
                num = cof[k] <<< (2*F);
                q = num / det;  // signed division truncates toward zero
                if (q > pmax) begin
                    q = pmax;
                    r.clip = 1'b1;
                end else if (q < nmin) begin
                    q = nmin;
                    r.clip = 1'b1;
                end
                r.e[k] = q[W-1:0];
            end
        end
        return r;
    endfunction

    function automatic elem_t rand_elem(int mode);
        elem_t v;
        case (mode)
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 8)) - 4 <<< F;
            2: v = $signed($urandom_range(0, 1 << 18)) - (1 << 17);
            default: v = ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
        endcase
        return v;
    endfunction

    task automatic add_mat(matrix_t m);
        pending_mats.push_back(m);
        total_items++;
    endtask

    // driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready_q)) begin
            // previous item taken (or none shown): pick next
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_mats.size() > 0 && !hold_sender) begin
                matrix_t m;
                m = pending_mats.pop_front();
                for (int k = 0; k < 9; k++) s_tdata[k*W +: W] <= m.e[k];
                s_tvalid <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 7);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (!aresetn || quiet_tail) begin
            m_tready <= aresetn;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 7);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tready_q <= 1'b1;
        end else begin
            s_tready_q <= !(s_tvalid && !s_tready);
            if (s_tvalid && s_tready) begin
                matrix_t m;
                for (int k = 0; k < 9; k++) m.e[k] = s_tdata[k*W +: W];
                expected_inv.push_back(invert(m));
                accepted <= accepted + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_inv.size() == 0) begin
                    $error("unexpected item on result channel");
                    errors <= errors + 1;
                end else begin
                    inverse_t x;
                    int bad;
                    x = expected_inv.pop_front();
                    bad = 0;
                    for (int k = 0; k < 9; k++)
                        if (m_tdata[k*W +: W] !== x.e[k]) begin
                            $error("out_e%0d expected %h got %h", k, x.e[k], m_tdata[k*W +: W]);
                            bad++;
                        end
                    if (m_tuser[0] !== x.sing) begin
                        $error("singular expected %b got %b", x.sing, m_tuser[0]);
                        bad++;
                    end
                    if (m_tuser[1] !== x.clip) begin
                        $error("clipped expected %b got %b", x.clip, m_tuser[1]);
                        bad++;
                    end
                    errors <= errors + bad;
                end
            end
        end
    end

    longint cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        matrix_t m;
        int mode;
        // identity, scaled diagonal, singular, extremes
        foreach (m.e[k]) m.e[k] = 0;
        m.e[0] = 1 << F; m.e[4] = 1 << F; m.e[8] = 1 << F;
        add_mat(m);
        m.e[0] = 2 << F; m.e[4] = -(4 << F); m.e[8] = 1 << (F-1);
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 0;
        add_mat(m);
        foreach (m.e[k]) m.e[k] = (k + 1) << F;  // rank two
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 32'sh7fffffff;
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 32'sh80000000;
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 0;
        m.e[0] = 1; m.e[4] = 1; m.e[8] = 1;  // tiny: inverse saturates
        add_mat(m);
        m.e[0] = -1; m.e[4] = 1; m.e[8] = 1;
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 0;
        m.e[0] = 32'sh80000000; m.e[4] = 32'sh80000000; m.e[8] = 32'sh80000000;
        add_mat(m);
        m.e[0] = 32'sh7fffffff; m.e[4] = 32'sh7fffffff; m.e[8] = 32'sh7fffffff;
        add_mat(m);
        foreach (m.e[k]) m.e[k] = 0;
        m.e[2] = 1 << F; m.e[4] = -(1 << F); m.e[6] = 3 << F;  // permutation
        add_mat(m);
        foreach (m.e[k]) m.e[k] = (k % 2) ? 32'sh7fffffff : 32'sh80000000;
        add_mat(m);
        for (int i = 0; i < 8; i++) begin
            foreach (m.e[k]) m.e[k] = rand_elem(i % 4);
            add_mat(m);
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk) aresetn = 1'b1;

        for (int i = 0; i < N_RANDOM; i++) begin
            mode = $urandom_range(0, 9);
            foreach (m.e[k]) m.e[k] = rand_elem(mode < 3 ? 0 : mode < 6 ? 1 :
                                                mode < 9 ? 2 : $urandom_range(0, 3));
            // make some rows dependent for the singular path
            if ($urandom_range(0, 11) == 0)
                for (int k = 0; k < 3; k++) m.e[6+k] = m.e[k];
            add_mat(m);
            if (i == N_RANDOM / 3) begin
                // let everything drain before continuing
                while (pending_mats.size() != 0) @(posedge aclk);
                hold_sender = 1;
                while (accepted < total_items - pending_mats.size() || expected_inv.size() != 0)
                    @(posedge aclk);
                hold_sender = 0;
            end
        end

        while (pending_mats.size() > N_RANDOM / 5) @(posedge aclk);
        quiet_tail = 1;

        while (accepted < total_items || expected_inv.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== matrix_inverse_3x3_unit.f =====
+incdir+hdl
hdl/mi3_pkg.sv
hdl/mi3_front.sv
hdl/mi3_div_lane.sv
hdl/matrix_inverse_3x3_unit.sv
tb/testbench.sv
